/* rtl/autotile_run_length_encoder_defines.svh */
// Assertion helpers used by atrle_back.
`ifndef AUTOTILE_RUN_LENGTH_ENCODER_DEFINES_SVH
`define AUTOTILE_RUN_LENGTH_ENCODER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define ATRLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ATRLE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/atrle_pkg.sv */
package atrle_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned DimW      = 9;
  localparam int unsigned OffW      = 17;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);

  localparam logic [DimW-1:0] DimMaxW = DimW'(MaxWidth);
  localparam logic [DimW-1:0] DimMaxH = DimW'(MaxHeight);
  localparam logic [7:0]      RunMax  = 8'd255;

  localparam logic OpTile  = 1'b0;
  localparam logic OpDrain = 1'b1;

  localparam logic CfgMapWidth  = 1'b0;
  localparam logic CfgMapHeight = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] tile;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      run_length;
    logic [4:0]      tile_code;
    logic [OffW-1:0] byte_offset;
    logic            row_first;
    logic            pair_last;
    logic            frame_last;
  } out_item_t;

  // classified tile, front to back
  typedef struct packed {
    logic            restart;
    logic            have_code;
    logic            row_end;
    logic            drain;
    logic [ColW-1:0] col;
    logic [4:0]      code;
  } cls_t;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

/* rtl/atrle_front.sv */
module atrle_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [atrle_pkg::DimW-1:0]     map_width_i,
  input  logic [atrle_pkg::DimW-1:0]     map_height_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  atrle_pkg::in_item_t            in_data_i,
  output logic                           push_o,
  output atrle_pkg::cls_t                push_data_o,
  input  logic                           q_full_i
);

  localparam int unsigned ColW = atrle_pkg::ColW;
  localparam int unsigned DimW = atrle_pkg::DimW;

  typedef struct packed {
    logic            restart;
    logic            have_code;
    logic            up_force;
    logic            row_end;
    logic            drain;
    logic            wall;
    logic            bank;
    logic [ColW-1:0] col;
  } stage_t;

  logic [ColW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic            done_q, done_d;
  logic            bank_q, bank_d;
  logic            fr_v_q, fr_v_d;
  stage_t          fr_q, fr_d;
  logic            win_center_q;

  logic mem0_q [atrle_pkg::MaxWidth];
  logic mem1_q [atrle_pkg::MaxWidth];
  logic rd0a_q, rd0b_q, rd1a_q, rd1b_q;

  logic [DimW-1:0] w, h, row_eff;
  logic [ColW-1:0] x, x_p1;
  logic            accept, adv, drain_ph, proc, row_end, restart, wall;
  logic            we0, we1;

  assign w        = atrle_pkg::clamp_dim(map_width_i, atrle_pkg::DimMaxW);
  assign h        = atrle_pkg::clamp_dim(map_height_i, atrle_pkg::DimMaxH);
  assign adv      = fr_v_q && !q_full_i;
  assign in_stall_o = fr_v_q && !adv;
  assign accept   = in_valid_i && !in_stall_o;

  assign restart  = done_q && (in_data_i.op == atrle_pkg::OpTile);
  assign row_eff  = done_q ? '0 : row_q;
  assign x        = done_q ? '0 : col_q;
  assign x_p1     = x + ColW'(1);
  assign drain_ph = row_eff >= h;
  assign proc     = !(done_q && (in_data_i.op == atrle_pkg::OpDrain)) &&
                    ((in_data_i.op == atrle_pkg::OpDrain) == drain_ph);
  assign row_end  = ({1'b0, x} + DimW'(1)) >= w;
  assign wall     = in_data_i.tile != '0;

  // bank_q low: mem0 holds the output row, mem1 the row above it
  assign we0 = accept && proc && !drain_ph && bank_q;
  assign we1 = accept && proc && !drain_ph && !bank_q;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    done_d = done_q;
    bank_d = bank_q;
    fr_v_d = adv ? 1'b0 : fr_v_q;
    fr_d   = fr_q;
    if (accept) begin
      fr_v_d       = proc;
      fr_d.restart   = restart;
      fr_d.have_code = row_eff >= DimW'(1);
      fr_d.up_force  = row_eff == DimW'(1);
      fr_d.row_end   = row_end;
      fr_d.drain     = drain_ph;
      fr_d.wall      = wall;
      fr_d.bank      = bank_q;
      fr_d.col       = x;
      if (proc) begin
        done_d = 1'b0;
        row_d  = row_eff;
        if (row_end) begin
          col_d = '0;
          if (drain_ph) begin
            done_d = 1'b1;
          end else begin
            bank_d = !bank_q;
            row_d  = row_eff + DimW'(1);
          end
        end else begin
          col_d = x_p1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      done_q <= 1'b0;
      bank_q <= 1'b0;
      fr_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      done_q <= done_d;
      bank_q <= bank_d;
      fr_v_q <= fr_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_q <= fr_d;
  end

  // port a: x+1 while holding the output row, else x; port b: x
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd0a_q <= mem0_q[bank_q ? x : x_p1];
      rd0b_q <= mem0_q[x];
      rd1a_q <= mem1_q[bank_q ? x_p1 : x];
      rd1b_q <= mem1_q[x];
    end
    if (we0) mem0_q[x] <= wall;
    if (we1) mem1_q[x] <= wall;
  end

  logic mid_right, mid_center, upper, left_b, up_b, right_b, down_b;
  logic [4:0] code;

  always_comb begin
    mid_right  = fr_q.bank ? rd1a_q : rd0a_q;
    mid_center = fr_q.bank ? rd1b_q : rd0b_q;
    upper      = fr_q.bank ? rd0b_q : rd1b_q;
    up_b       = fr_q.up_force || upper;
    right_b    = fr_q.row_end || mid_right;
    down_b     = fr_q.drain || fr_q.wall;
    left_b     = (fr_q.col == '0) || win_center_q;
    // mask bits: left=8, down=4, right=2, up=1
    code       = mid_center ? 5'd1 + {1'b0, left_b, down_b, right_b, up_b} : 5'd0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) win_center_q <= mid_center;
  end

  assign push_o                = adv;
  assign push_data_o.restart   = fr_q.restart;
  assign push_data_o.have_code = fr_q.have_code;
  assign push_data_o.row_end   = fr_q.row_end;
  assign push_data_o.drain     = fr_q.drain;
  assign push_data_o.col       = fr_q.col;
  assign push_data_o.code      = code;

endmodule

/* rtl/atrle_fifo.sv */
module atrle_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  atrle_pkg::cls_t push_data_i,
  output logic            full_o,
  output logic            valid_o,
  output atrle_pkg::cls_t data_o,
  input  logic            pop_i
);

  localparam int unsigned PtrW = atrle_pkg::QPtrW;
  localparam int unsigned CntW = PtrW + 1;

  atrle_pkg::cls_t  mem_q [atrle_pkg::QDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(atrle_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PtrW'(1);
      if (do_pop)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

/* rtl/atrle_back.sv */
`include "autotile_run_length_encoder_defines.svh"

module atrle_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  atrle_pkg::cls_t      q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output atrle_pkg::out_item_t out_data_o
);

  localparam int unsigned OffW = atrle_pkg::OffW;
  localparam int unsigned DimW = atrle_pkg::DimW;

  logic [OffW-1:0] off_q, off_d, off0, off_b;
  logic            open_q, open_d, open0;
  logic [7:0]      cnt_q, cnt_d, cnt0, ncnt;
  logic [4:0]      code_q, code_d, code0, ncode;
  logic            out_v_q, out_v_d, pend_v_q, pend_v_d;
  atrle_pkg::out_item_t out_q, out_d, pend_q, pend_d, pa, pb;
  logic            out_free, cont, pa_v, pb_v;
  atrle_pkg::cls_t r;

  assign r        = q_data_i;
  assign out_free = !out_v_q || !out_stall_i;
  assign q_pop_o  = q_valid_i && out_free && !pend_v_q;

  always_comb begin
    off0  = r.restart ? '0 : off_q;
    open0 = r.restart ? 1'b0 : open_q;
    cnt0  = r.restart ? '0 : cnt_q;
    code0 = r.restart ? '0 : code_q;
    cont  = open0 && (r.code == code0) && (cnt0 != atrle_pkg::RunMax);
    pa_v  = r.have_code && !cont && open0;
    pb_v  = r.have_code && r.row_end;
    ncnt  = cont ? cnt0 + 8'd1 : 8'd1;
    ncode = cont ? code0 : r.code;
    off_b = pa_v ? off0 + OffW'(2) : off0;

    pa.run_length  = cnt0;
    pa.tile_code   = code0;
    pa.byte_offset = off0;
    pa.row_first   = cnt0 == r.col;
    pa.pair_last   = !pb_v;
    pa.frame_last  = 1'b0;

    pb.run_length  = ncnt;
    pb.tile_code   = ncode;
    pb.byte_offset = off_b;
    pb.row_first   = {1'b0, ncnt} == ({1'b0, r.col} + DimW'(1));
    pb.pair_last   = 1'b1;
    pb.frame_last  = r.drain;

    off_d  = off_q;
    open_d = open_q;
    cnt_d  = cnt_q;
    code_d = code_q;
    if (q_pop_o) begin
      off_d  = pb_v ? off_b + OffW'(2) : off_b;
      open_d = open0;
      cnt_d  = cnt0;
      code_d = code0;
      if (r.have_code) begin
        open_d = !r.row_end;
        cnt_d  = r.row_end ? 8'd0 : ncnt;
        code_d = ncode;
      end
    end

    out_v_d  = out_v_q;
    out_d    = out_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    if (out_free) begin
      if (pend_v_q) begin
        out_v_d  = 1'b1;
        out_d    = pend_q;
        pend_v_d = 1'b0;
      end else if (q_pop_o && (pa_v || pb_v)) begin
        out_v_d  = 1'b1;
        out_d    = pa_v ? pa : pb;
        pend_v_d = pa_v && pb_v;
        pend_d   = pb;
      end else begin
        out_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      open_q   <= 1'b0;
      cnt_q    <= '0;
      code_q   <= '0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      off_q    <= off_d;
      open_q   <= open_d;
      cnt_q    <= cnt_d;
      code_q   <= code_d;
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `ATRLE_ASSERT(a_pend_behind_out, pend_v_q |-> out_v_q, "second pair without a first")
  `ATRLE_ASSERT(a_run_nonempty, open_q |-> (cnt_q != '0), "open run with zero length")
  `ATRLE_ASSERT(a_len_nonzero, out_v_q |-> (out_q.run_length != '0), "empty pair")
  `ATRLE_ASSERT(a_code_range, out_v_q |-> (out_q.tile_code <= 5'd16), "tile code out of range")

endmodule

/* rtl/autotile_run_length_encoder.sv */
// Channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | in_data_i  (op, tile)
// out     | out_valid_o| out_stall_i | out_data_o (run pair)
// cfg     | cfg_we_i   | -           | cfg_index_i, cfg_data_i
//
// One request per cycle while in_stall_o is low; the front reads both row
// memories on accept. A request closing a run at row end gives two pairs,
// the second held in a pending register that blocks further queue pops.
// Reset clears counters and run state; the row memories hold no reset.
// Either side may stall; a two-entry queue separates front and back.
module autotile_run_length_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  atrle_pkg::in_item_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output atrle_pkg::out_item_t           out_data_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [atrle_pkg::DimW-1:0]     cfg_data_i
);

  logic [atrle_pkg::DimW-1:0] map_width_q, map_height_q;
  logic                       push, q_full, q_valid, q_pop;
  atrle_pkg::cls_t            push_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= atrle_pkg::DimMaxW;
      map_height_q <= atrle_pkg::DimMaxH;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        atrle_pkg::CfgMapWidth:  map_width_q  <= cfg_data_i;
        atrle_pkg::CfgMapHeight: map_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  atrle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .q_full_i     (q_full)
  );

  atrle_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  atrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
